>>> sv/mddm_pkg.sv
// mddm_pkg: shared constants, codes and types of the min-distance symbol demapper
// used by mddm_dist, min_distance_symbol_demapper_core and mddm_checker
// no dependencies

package mddm_pkg;

   // defaults for the top-level parameters
   localparam int MAX_POINTS_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths
   localparam int IDX_W      = 6;
   localparam int MOD_W      = 2;
   localparam int CNT_W      = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // operation codes
   localparam logic OP_DEMAP = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   // modulation codes
   localparam logic [MOD_W-1:0] MOD_BPSK  = 2'd0;
   localparam logic [MOD_W-1:0] MOD_QPSK  = 2'd1;
   localparam logic [MOD_W-1:0] MOD_QAM16 = 2'd2;
   localparam logic [MOD_W-1:0] MOD_QAM64 = 2'd3;

   // register index of the modulation register
   localparam logic REG_MODULATION = 1'b0;

   // tag that travels with each point through the distance unit
   typedef struct packed {
      logic vld;
      logic is_last;
   } tag_type;

   // number of constellation points searched for a modulation code
   function automatic logic [CNT_W-1:0] mod_points(input logic [MOD_W-1:0] modulation);
      logic [CNT_W-1:0] pts;
      case (modulation)
         MOD_BPSK:  pts = CNT_W'(2);
         MOD_QPSK:  pts = CNT_W'(4);
         MOD_QAM16: pts = CNT_W'(16);
         MOD_QAM64: pts = CNT_W'(64);
         default:   pts = CNT_W'(4);
      endcase
      return pts;
   endfunction

endpackage

>>> sv/min_distance_symbol_demapper_core.sv
// min_distance_symbol_demapper_core: top level of the hard-decision demapper
// point table, read sequencer, running minimum, result register and csr port
// depends on mddm_pkg and mddm_dist

// A load item (operation 1) writes one (I,Q) point into the point table; no
// result comes of it. A demap item (operation 0) searches the first N points
// of the table, N being 2, 4, 16 or 64 as the modulation register selects (at
// most MAX_POINTS), for the least squared distance to the sample and returns
// that point's index; ties keep the lower index, and in BPSK only the I
// distance to points 0 and 1 counts, with a tie giving 1. The table has one
// read port and the single distance unit takes one point per cycle, followed
// by a short pipeline and the result hand-off. req_stall stays high while a
// demap is in progress. A finished result waits in the output register, so a
// following item can be accepted while it is still stalled. Table entries read
// before they were loaded give undefined indexes.

module min_distance_symbol_demapper_core #(
   parameter int MAX_POINTS  = mddm_pkg::MAX_POINTS_DEF,
   parameter int SAMPLE_BITS = mddm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [mddm_pkg::IDX_W-1:0]          req_point_index,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_q,
   input  logic                                req_last_sample,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mddm_pkg::IDX_W-1:0]          rsp_symbol_index,
   output logic                                rsp_last_symbol,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mddm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mddm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mddm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DW     = SAMPLE_BITS;
   localparam int CW     = mddm_pkg::CNT_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   logic [mddm_pkg::MOD_W-1:0]  mod_ff;
   logic                        req_acc;
   logic                        demap_acc;
   logic                        load_acc;
   logic                        csr_wr;
   logic                        rsp_free;

   // point table, I in the upper half and Q in the lower half
   logic [2*DW-1:0]             table_mem [MAX_POINTS];
   logic [2*DW-1:0]             rd_data_ff;
   mddm_pkg::tag_type           rd_tag_ff;

   logic [ADDR_W-1:0]           addr_ff;
   logic [ADDR_W-1:0]           last_addr_ff;
   logic [ADDR_W-1:0]           last_addr_in;
   logic [CW-1:0]               pts_m1;
   logic [CW-1:0]               lim_m1;

   logic signed [DW-1:0]        smp_i_ff;
   logic signed [DW-1:0]        smp_q_ff;
   logic                        last_ff;
   logic                        bpsk_ff;

   mddm_pkg::tag_type           dist_tag;
   logic [2*DW:0]               sq_dist;
   logic [2*DW:0]               best_d_ff;
   logic [ADDR_W-1:0]           best_k_ff;
   logic [ADDR_W-1:0]           cmp_k_ff;
   logic                        take;

   logic                        rsp_valid_ff;
   logic [mddm_pkg::IDX_W-1:0]  rsp_idx_ff;
   logic                        rsp_last_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign demap_acc = req_acc && (req_operation == mddm_pkg::OP_DEMAP);
   assign load_acc  = req_acc && (req_operation == mddm_pkg::OP_LOAD)
                      && (CW'(req_point_index) < CW'(MAX_POINTS));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= mddm_pkg::MOD_QPSK;
      end else if (csr_wr && (csr_paddr[2] == mddm_pkg::REG_MODULATION)) begin
         mod_ff <= csr_pwdata[mddm_pkg::MOD_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == mddm_pkg::REG_MODULATION) begin
         csr_prdata = mddm_pkg::CSR_DATA_W'(mod_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // last table entry to visit: point count clipped to the table size
   always_comb begin
      pts_m1 = mddm_pkg::mod_points(mod_ff) - CW'(1);
      lim_m1 = CW'(MAX_POINTS - 1);
      last_addr_in = (pts_m1 < lim_m1) ? ADDR_W'(pts_m1) : ADDR_W'(lim_m1);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (demap_acc) state_in = ST_ISSUE;
         ST_ISSUE: if (addr_ff == last_addr_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (dist_tag.vld && dist_tag.is_last) state_in = ST_HOLD;
         ST_HOLD:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch the item and restart the address counter
   always_ff @(posedge clock) begin
      if (demap_acc) begin
         smp_i_ff     <= req_sample_i;
         smp_q_ff     <= req_sample_q;
         last_ff      <= req_last_sample;
         bpsk_ff      <= (mod_ff == mddm_pkg::MOD_BPSK);
         last_addr_ff <= last_addr_in;
         addr_ff      <= '0;
      end else if (state_ff == ST_ISSUE) begin
         addr_ff <= addr_ff + ADDR_W'(1);
      end
   end

   // table: one write port for loads, one registered read port for the search
   always_ff @(posedge clock) begin
      if (load_acc) begin
         table_mem[ADDR_W'(req_point_index)] <= {req_sample_i, req_sample_q};
      end
      if (state_ff == ST_ISSUE) begin
         rd_data_ff <= table_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff.vld     <= (state_ff == ST_ISSUE);
         rd_tag_ff.is_last <= (state_ff == ST_ISSUE) && (addr_ff == last_addr_ff);
      end
   end

   mddm_dist #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (rd_tag_ff),
      .smp_i   (smp_i_ff),
      .smp_q   (smp_q_ff),
      .pt_i    (rd_data_ff[2*DW-1:DW]),
      .pt_q    (rd_data_ff[DW-1:0]),
      .i_only  (bpsk_ff),
      .tag_out (dist_tag),
      .sq_dist (sq_dist)
   );

   // running minimum; bpsk lets the later point win a tie
   always_comb begin
      if (cmp_k_ff == '0) begin
         take = dist_tag.vld;
      end else if (bpsk_ff) begin
         take = dist_tag.vld && (sq_dist <= best_d_ff);
      end else begin
         take = dist_tag.vld && (sq_dist < best_d_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (demap_acc) begin
         cmp_k_ff <= '0;
      end else if (dist_tag.vld) begin
         cmp_k_ff <= cmp_k_ff + ADDR_W'(1);
      end
      if (take) begin
         best_d_ff <= sq_dist;
         best_k_ff <= cmp_k_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_HOLD && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_HOLD && rsp_free) begin
         rsp_idx_ff  <= mddm_pkg::IDX_W'(best_k_ff);
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_index = rsp_idx_ff;
   assign rsp_last_symbol  = rsp_last_ff;

endmodule

>>> sv/mddm_dist.sv
// mddm_dist: pipelined squared-distance unit, one point per cycle
// absolute differences, then squares, then the summed distance
// depends on mddm_pkg

module mddm_dist #(
   parameter int SAMPLE_BITS = mddm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mddm_pkg::tag_type             tag_in,
   input  logic signed [SAMPLE_BITS-1:0] smp_i,
   input  logic signed [SAMPLE_BITS-1:0] smp_q,
   input  logic signed [SAMPLE_BITS-1:0] pt_i,
   input  logic signed [SAMPLE_BITS-1:0] pt_q,
   input  logic                          i_only,
   output mddm_pkg::tag_type             tag_out,
   output logic [2*SAMPLE_BITS:0]        sq_dist
);

   localparam int DW = SAMPLE_BITS;

   logic signed [DW:0]   diff_i;
   logic signed [DW:0]   diff_q;
   logic [DW-1:0]        abs_i_in;
   logic [DW-1:0]        abs_q_in;
   logic [DW-1:0]        abs_i_ff;
   logic [DW-1:0]        abs_q_ff;
   logic [2*DW-1:0]      sq_i_ff;
   logic [2*DW-1:0]      sq_q_ff;
   mddm_pkg::tag_type    tag1_ff;
   mddm_pkg::tag_type    tag2_ff;

   // difference of two DW-bit values fits DW bits once made positive
   always_comb begin
      diff_i = {smp_i[DW-1], smp_i} - {pt_i[DW-1], pt_i};
      diff_q = {smp_q[DW-1], smp_q} - {pt_q[DW-1], pt_q};
      abs_i_in = diff_i[DW] ? DW'(-diff_i) : diff_i[DW-1:0];
      if (i_only) begin
         abs_q_in = '0;
      end else begin
         abs_q_in = diff_q[DW] ? DW'(-diff_q) : diff_q[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      abs_i_ff <= abs_i_in;
      abs_q_ff <= abs_q_in;
      sq_i_ff  <= abs_i_ff * abs_i_ff;
      sq_q_ff  <= abs_q_ff * abs_q_ff;
   end

   assign tag_out = tag2_ff;
   assign sq_dist = {1'b0, sq_i_ff} + {1'b0, sq_q_ff};

endmodule

>>> sv/mddm_checker.sv
// mddm_checker: port-level assertions for min_distance_symbol_demapper_core
// attached to the top level by the bind statement at the end of this file
// depends on mddm_pkg

module mddm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_operation,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [mddm_pkg::IDX_W-1:0] rsp_symbol_index,
   input logic                       rsp_last_symbol
);

   // a demap item keeps the block busy for the search
   a_demap_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == mddm_pkg::OP_DEMAP) |=> req_stall)
      else $error("demap item accepted but block not busy next cycle");

   // a load item does not make the block busy
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == mddm_pkg::OP_LOAD) |=> !req_stall)
      else $error("load item left the block busy");

   // a new result only comes out of a search in progress
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a search");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_symbol_index) && $stable(rsp_last_symbol))
      else $error("stalled result changed");

endmodule

bind min_distance_symbol_demapper_core mddm_checker u_mddm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_symbol_index (rsp_symbol_index),
   .rsp_last_symbol  (rsp_last_symbol)
);

>>> tb/min_distance_symbol_demapper_core_tb.sv
`timescale 1ns / 1ps
// min_distance_symbol_demapper_core_tb: self-checking bench for the demapper core
// loads constellation tables, demaps samples under random gaps and stalls, checks each index
// depends on mddm_pkg and min_distance_symbol_demapper_core

module min_distance_symbol_demapper_core_tb;

   localparam int SB   = mddm_pkg::SAMPLE_BITS_DEF;
   localparam int NPTS = mddm_pkg::MAX_POINTS_DEF;
   localparam int SMAX = 2 ** (SB - 1) - 1;
   localparam int SMIN = -(2 ** (SB - 1));
   localparam logic [mddm_pkg::CSR_ADDR_W-1:0] MODULATION_ADDR =
      mddm_pkg::CSR_ADDR_W'(4 * mddm_pkg::REG_MODULATION);

   typedef struct packed {
      logic [mddm_pkg::IDX_W-1:0] symbol_index;
      logic                       last_symbol;
   } symbol_result_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_operation = mddm_pkg::OP_DEMAP;
   logic [mddm_pkg::IDX_W-1:0]          req_point_index = '0;
   logic signed [SB-1:0]                req_sample_i = '0;
   logic signed [SB-1:0]                req_sample_q = '0;
   logic                                req_last_sample = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [mddm_pkg::IDX_W-1:0]          rsp_symbol_index;
   logic                                rsp_last_symbol;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [mddm_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [mddm_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [mddm_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   min_distance_symbol_demapper_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_point_index  (req_point_index),
      .req_sample_i     (req_sample_i),
      .req_sample_q     (req_sample_q),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol_index (rsp_symbol_index),
      .rsp_last_symbol  (rsp_last_symbol),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("min_distance_symbol_demapper_core test failed");
      $finish;
   end

   // mirror of the point table and the modulation register
   logic signed [SB-1:0]          point_i [NPTS];
   logic signed [SB-1:0]          point_q [NPTS];
   logic [mddm_pkg::MOD_W-1:0]    modulation_mirror = mddm_pkg::MOD_QPSK;
   symbol_result_type             pending_symbols [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int checked_count = 0;
   int load_count = 0;
   int demaps_per_mode [4] = '{0, 0, 0, 0};

   function automatic int points_searched(input logic [mddm_pkg::MOD_W-1:0] m);
      case (m)
         mddm_pkg::MOD_BPSK:  return 2;
         mddm_pkg::MOD_QPSK:  return 4;
         mddm_pkg::MOD_QAM16: return 16;
         default:             return 64;  // qam64
      endcase
   endfunction

   function automatic longint abs_diff(input logic signed [SB-1:0] a, b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic [mddm_pkg::IDX_W-1:0] nearest_point(
      input logic signed [SB-1:0] si, sq);
      longint cur_dist, best_dist, di, dq;
      int n;
      logic [mddm_pkg::IDX_W-1:0] best;
      best = '0;
      if (modulation_mirror == mddm_pkg::MOD_BPSK) begin
         // i distance only, tie goes to point 1
         best = (abs_diff(si, point_i[0]) < abs_diff(si, point_i[1])) ?
                mddm_pkg::IDX_W'(0) : mddm_pkg::IDX_W'(1);
      end else begin
         n = points_searched(modulation_mirror);
         if (n > NPTS) n = NPTS;
         best_dist = 0;
         for (int k = 0; k < n; k++) begin
            di = abs_diff(si, point_i[k]);
            dq = abs_diff(sq, point_q[k]);
            cur_dist = di * di + dq * dq;
            if (k == 0 || cur_dist < best_dist) begin
               best_dist = cur_dist;
               best = mddm_pkg::IDX_W'(k);
            end
         end
      end
      return best;
   endfunction

   function automatic logic signed [SB-1:0] clamp_sample(input int v);
      if (v > SMAX) return SB'(SMAX);
      if (v < SMIN) return SB'(SMIN);
      return SB'(v);
   endfunction

   function automatic logic signed [SB-1:0] corner_value();
      case ($urandom_range(3))
         0:       return SB'(SMIN);
         1:       return SB'(SMAX);
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      symbol_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_symbols.size() == 0) begin
            $error("result with nothing pending: symbol_index %0d last_symbol %0d",
                   rsp_symbol_index, rsp_last_symbol);
            mismatch_count++;
         end else begin
            want = pending_symbols.pop_front();
            checked_count++;
            if (rsp_symbol_index !== want.symbol_index) begin
               $error("symbol_index mismatch: expected %0d, actual %0d",
                      want.symbol_index, rsp_symbol_index);
               mismatch_count++;
            end
            if (rsp_last_symbol !== want.last_symbol) begin
               $error("last_symbol mismatch: expected %0d, actual %0d",
                      want.last_symbol, rsp_last_symbol);
               mismatch_count++;
            end
         end
      end
   end

   // valid stays high after acceptance so back-to-back items need no second assignment
   task automatic send_item(input logic op, input logic [mddm_pkg::IDX_W-1:0] idx,
                            input logic signed [SB-1:0] si, sq, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_point_index <= idx;
      req_sample_i    <= si;
      req_sample_q    <= sq;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == mddm_pkg::OP_LOAD) begin
         point_i[idx] = si;
         point_q[idx] = sq;
         load_count++;
      end else begin
         pending_symbols.push_back('{nearest_point(si, sq), last});
         demaps_per_mode[modulation_mirror]++;
      end
   endtask

   task automatic demap(input logic signed [SB-1:0] si, sq, input logic last);
      send_item(mddm_pkg::OP_DEMAP, mddm_pkg::IDX_W'($urandom_range(63)), si, sq, last);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_modulation(input logic [mddm_pkg::MOD_W-1:0] m);
      settle_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODULATION_ADDR;
      csr_pwdata  <= ($urandom() & ~mddm_pkg::CSR_DATA_W'(3)) | mddm_pkg::CSR_DATA_W'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      modulation_mirror = m;
   endtask

   // regular square grid for the mode, bpsk as two points at opposite i values with random q
   task automatic load_grid(input logic [mddm_pkg::MOD_W-1:0] m, input bit full_scale);
      int n, levels, span, amp, ci, cq;
      n = points_searched(m);
      levels = (n == 64) ? 8 : (n == 16) ? 4 : 2;
      span = (n == 2) ? 1 : levels - 1;
      amp = full_scale ? SMAX / span : $urandom_range(SMAX / span, 1);
      for (int k = 0; k < n; k++) begin
         if (n == 2) begin
            ci = (2 * k - 1) * amp;
            cq = int'($urandom_range(2000)) - 1000;
         end else begin
            ci = (2 * (k / levels) - (levels - 1)) * amp;
            cq = (2 * (k % levels) - (levels - 1)) * amp;
         end
         send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'(k), SB'(ci), SB'(cq),
                   1'($urandom_range(1)));
      end
   endtask

   task automatic test_directed_corners();
      // whole table is written first so no search reaches an unloaded entry
      load_grid(mddm_pkg::MOD_QAM64, 1'b1);
      // qpsk out of reset, with extreme points and a duplicate of entry 0
      send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'(2), SB'(SMAX), SB'(SMAX), 1'b0);
      send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'(3), SB'(SMIN), SB'(SMIN), 1'b1);
      send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'(1), point_i[0], point_q[0], 1'b0);
      demap(SB'(SMAX), SB'(SMAX), 1'b0);
      demap(SB'(SMIN), SB'(SMIN), 1'b1);
      demap(SB'(SMIN), SB'(SMAX), 1'b0);
      demap(point_i[0], point_q[0], 1'b1);
      demap('0, '0, 1'b0);
      // bpsk: midpoint tie goes to point 1
      write_modulation(mddm_pkg::MOD_BPSK);
      send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'(0), SB'(-1000), SB'(77), 1'b1);
      send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'(1), SB'(1000), SB'(-5), 1'b0);
      demap('0, SB'(SMAX), 1'b0);
      demap('1, '0, 1'b1);
      demap(SB'(1), SB'(SMIN), 1'b0);
      demap(SB'(SMIN), '0, 1'b0);
      demap(SB'(SMAX), '0, 1'b1);
      // qam16 and qam64: origin is equidistant from the centre points
      write_modulation(mddm_pkg::MOD_QAM16);
      load_grid(mddm_pkg::MOD_QAM16, 1'b1);
      demap('0, '0, 1'b1);
      demap(SB'(SMAX), SB'(SMIN), 1'b0);
      write_modulation(mddm_pkg::MOD_QAM64);
      load_grid(mddm_pkg::MOD_QAM64, 1'b1);
      demap('0, '0, 1'b0);
      demap(SB'(SMIN), SB'(SMIN), 1'b1);
      demap(SB'(SMAX), SB'(SMAX), 1'b0);
   endtask

   task automatic run_random_chunk(input logic [mddm_pkg::MOD_W-1:0] m, input int count);
      int n, k, j, sel;
      logic signed [SB-1:0] si, sq;
      write_modulation(m);
      if ($urandom_range(1)) load_grid(m, $urandom_range(3) == 0);
      n = points_searched(m);
      repeat (count) begin
         sel = $urandom_range(99);
         k = $urandom_range(n - 1);
         j = $urandom_range(n - 1);
         if (sel < 15) begin
            // occasional table rewrite; copies of other entries give exact ties
            j = $urandom_range(NPTS - 1);
            case ($urandom_range(2))
               0: begin si = point_i[j]; sq = point_q[j]; end
               1: begin
                  si = clamp_sample((int'($urandom_range(16)) - 8) * 4096);
                  sq = corner_value();
               end
               default: begin si = SB'($urandom()); sq = SB'($urandom()); end
            endcase
            send_item(mddm_pkg::OP_LOAD, mddm_pkg::IDX_W'($urandom_range(NPTS - 1)),
                      si, sq, 1'($urandom_range(1)));
         end else begin
            sel = $urandom_range(99);
            if (sel < 25) begin
               si = SB'($urandom());
               sq = SB'($urandom());
            end else if (sel < 55) begin
               si = clamp_sample(int'(point_i[k]) + int'($urandom_range(512)) - 256);
               sq = clamp_sample(int'(point_q[k]) + int'($urandom_range(512)) - 256);
            end else if (sel < 75) begin
               si = clamp_sample((int'(point_i[k]) + int'(point_i[j])) >>> 1);
               sq = clamp_sample((int'(point_q[k]) + int'(point_q[j])) >>> 1);
            end else if (sel < 90) begin
               si = corner_value();
               sq = corner_value();
            end else begin
               si = point_i[k];
               sq = point_q[k];
            end
            demap(si, sq, $urandom_range(99) < 30);
         end
      end
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct);
      logic [mddm_pkg::MOD_W-1:0] modes [$];
      modes = '{mddm_pkg::MOD_BPSK, mddm_pkg::MOD_QPSK,
                mddm_pkg::MOD_QAM16, mddm_pkg::MOD_QAM64};
      repeat ($urandom_range(3)) modes.push_back(modes.pop_front());
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      foreach (modes[i]) run_random_chunk(modes[i], 160);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 23;
      recv_idle_pct = 78;
      test_directed_corners();
      test_random_phase(23, 78);
      test_random_phase(78, 23);
      test_random_phase(0, 0);
      settle_idle();
      if (pending_symbols.size() != 0) mismatch_count++;
      $display("demapped %0d bpsk, %0d qpsk, %0d qam16, %0d qam64 samples; %0d points loaded",
               demaps_per_mode[mddm_pkg::MOD_BPSK], demaps_per_mode[mddm_pkg::MOD_QPSK],
               demaps_per_mode[mddm_pkg::MOD_QAM16], demaps_per_mode[mddm_pkg::MOD_QAM64],
               load_count);
      $display("%0d results compared, %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("min_distance_symbol_demapper_core test passed");
      end else begin
         $display("min_distance_symbol_demapper_core test failed");
      end
      $finish;
   end

endmodule
